// ===== sv/tlw_pkg.sv =====
package tlw_pkg;

  localparam int LINE_LEN_DEF = 40;
  localparam int DATA_W       = 8;
  localparam int KIND_W       = 3;
  localparam int COLS_W       = 6;
  localparam int COLS_MAX     = 63;
  localparam int CFG_IDX_W    = 2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ECHO  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ERASE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BELL  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LINE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_END   = 3'd4;

  // fixed bytes
  localparam logic [DATA_W-1:0] NEWLINE_BYTE = 8'd10;
  localparam logic [DATA_W-1:0] BELL_BYTE    = 8'd7;
  localparam logic [DATA_W-1:0] SPACE_BYTE   = 8'd32;
  localparam logic [DATA_W-1:0] TILDE_BYTE   = 8'd126;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EOF   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KILL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WERASE = 2'd3;

  // register reset values
  localparam logic [DATA_W-1:0] EOF_RST    = 8'd4;
  localparam logic [DATA_W-1:0] ERASE_RST  = 8'd127;
  localparam logic [DATA_W-1:0] KILL_RST   = 8'd21;
  localparam logic [DATA_W-1:0] WERASE_RST = 8'd23;

endpackage

// ===== sv/tlw_ram.sv =====
module tlw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 41
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/tty_line_editor_with_wrap.sv =====
// Line editor with word wrap. One item in, 0 to LINE_LEN+4 results out.
// Bell, echo, erase, kill and eof: accept and decode states, plus output stalls.
// Newline reads out the stored line. Word erase walks back one store read per step.
// Wrap walks back to the last space; one line-store read port paces every walk.
// One item at a time: in_ready only in idle. Sync active-low reset clears
// control, count, end-of-input flag and registers; the line store is not cleared.
module tty_line_editor_with_wrap
  import tlw_pkg::*;
#(
  parameter int LINE_LEN = LINE_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // typed bytes
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DATA_W-1:0]    in_byte,
  // results
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KIND_W-1:0]    out_kind,
  output logic [DATA_W-1:0]    out_byte,
  output logic [COLS_W-1:0]    out_erase_columns,
  output logic                 out_input_ended,
  output logic                 out_last_result,
  // register writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  localparam int DEPTH = LINE_LEN + 1;
  localparam int AW    = $clog2(DEPTH);
  // count holds 0..LINE_LEN+1
  localparam int CW    = $clog2(LINE_LEN + 2);
  localparam logic [CW-1:0] FULL_CNT = CW'(LINE_LEN);
  localparam logic [CW-1:0] LAST_CNT = CW'(LINE_LEN + 1);
  localparam logic [CW-1:0] ONE      = CW'(1);
  localparam logic [CW-1:0] TWO      = CW'(2);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DEC    = 9'b000000010,
    S_WSCAN  = 9'b000000100,  // word erase walk
    S_WFIN   = 9'b000001000,
    S_XSCAN  = 9'b000010000,  // wrap: look for last space
    S_TERASE = 9'b000100000,  // wrap: rub out tail
    S_LINE   = 9'b001000000,  // completed line bytes
    S_LEND   = 9'b010000000,  // line end marker
    S_COPY   = 9'b100000000   // wrap: move tail down and re-echo
  } state_t;

  function automatic logic [COLS_W-1:0] sat_cols(input logic [CW-1:0] v);
    return (32'(v) > 32'(COLS_MAX)) ? COLS_W'(COLS_MAX) : COLS_W'(v);
  endfunction

  state_t            state_r, state_nxt;
  logic [DATA_W-1:0] c_r, c_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;    // scan position p, examines entry p-1
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     len_r, len_nxt;    // bytes of the completed line
  logic [CW-1:0]     tail_r, tail_nxt;  // wrapped tail length
  logic              copy_r, copy_nxt;  // tail follows the line end
  logic              wphase_r, wphase_nxt;
  logic              done_r, done_nxt;

  logic [DATA_W-1:0] eof_r, erase_r, kill_r, werase_r;

  logic              out_valid_r;
  logic [KIND_W-1:0] kind_r;
  logic [DATA_W-1:0] byte_r;
  logic [COLS_W-1:0] cols_r;
  logic              ended_r, last_r;

  // result builder
  logic              emit;
  logic [KIND_W-1:0] e_kind;
  logic [DATA_W-1:0] e_byte;
  logic [CW-1:0]     e_cnt;
  logic              e_ended, e_last;
  logic              slot;

  // line store port
  logic              ram_we;
  logic [CW-1:0]     ram_wsel, ram_rsel;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  logic              rd_space;

  assign slot     = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign rd_space = (ram_rdata == SPACE_BYTE);

  tlw_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wsel[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_rsel[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Store reads are registered: the address picked here is the entry seen next cycle.
  always_comb begin
    state_nxt  = state_r;
    c_nxt      = c_r;
    cnt_nxt    = cnt_r;
    ptr_nxt    = ptr_r;
    idx_nxt    = idx_r;
    len_nxt    = len_r;
    tail_nxt   = tail_r;
    copy_nxt   = copy_r;
    wphase_nxt = wphase_r;
    done_nxt   = done_r;
    emit       = 1'b0;
    e_kind     = KIND_ECHO;
    e_byte     = '0;
    e_cnt      = '0;
    e_ended    = 1'b0;
    e_last     = 1'b0;
    ram_we     = 1'b0;
    ram_wsel   = cnt_r;
    ram_wdata  = c_r;
    ram_rsel   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          c_nxt     = in_byte;
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        if (done_r) begin
          state_nxt = S_IDLE;
        end else if (c_r == eof_r) begin
          if (cnt_r != '0) begin
            state_nxt = S_IDLE;
          end else if (slot) begin
            emit      = 1'b1;
            e_kind    = KIND_END;
            e_byte    = NEWLINE_BYTE;
            e_ended   = 1'b1;
            e_last    = 1'b1;
            done_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (c_r == erase_r) begin
          if (cnt_r == '0) begin
            state_nxt = S_IDLE;
          end else if (slot) begin
            emit      = 1'b1;
            e_kind    = KIND_ERASE;
            e_cnt     = ONE;
            e_last    = 1'b1;
            cnt_nxt   = cnt_r - ONE;
            state_nxt = S_IDLE;
          end
        end else if (c_r == kill_r) begin
          if (cnt_r == '0) begin
            state_nxt = S_IDLE;
          end else if (slot) begin
            emit      = 1'b1;
            e_kind    = KIND_ERASE;
            e_cnt     = cnt_r;
            e_last    = 1'b1;
            cnt_nxt   = '0;
            state_nxt = S_IDLE;
          end
        end else if (c_r == werase_r) begin
          if (cnt_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt    = cnt_r;
            wphase_nxt = 1'b0;
            ram_rsel   = cnt_r - ONE;
            state_nxt  = S_WSCAN;
          end
        end else if (c_r == NEWLINE_BYTE) begin
          idx_nxt   = '0;
          len_nxt   = cnt_r;
          copy_nxt  = 1'b0;
          state_nxt = S_LINE;
        end else if (c_r < SPACE_BYTE || c_r > TILDE_BYTE) begin
          if (slot) begin
            emit      = 1'b1;
            e_kind    = KIND_BELL;
            e_byte    = BELL_BYTE;
            e_last    = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (slot) begin
          // printable: echo and store; the line never holds more than LINE_LEN here
          emit    = 1'b1;
          e_kind  = KIND_ECHO;
          e_byte  = c_r;
          ram_we  = 1'b1;
          cnt_nxt = cnt_r + ONE;
          if (cnt_r == FULL_CNT) begin
            if (c_r == SPACE_BYTE) begin
              // wrap right after a space: whole line goes, nothing carried over
              idx_nxt   = '0;
              len_nxt   = LAST_CNT;
              copy_nxt  = 1'b0;
              state_nxt = S_LINE;
            end else begin
              // new byte is not a space, so the walk starts one entry lower
              ptr_nxt   = FULL_CNT;
              ram_rsel  = FULL_CNT - ONE;
              state_nxt = S_XSCAN;
            end
          end else begin
            e_last    = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end

      S_WSCAN: begin
        // trailing spaces first, then one word
        if (!wphase_r || !rd_space) begin
          ptr_nxt    = ptr_r - ONE;
          wphase_nxt = wphase_r || !rd_space;
          if (ptr_r == ONE) begin
            state_nxt = S_WFIN;
          end else begin
            ram_rsel = ptr_r - TWO;
          end
        end else begin
          state_nxt = S_WFIN;
        end
      end

      S_WFIN: begin
        if (slot) begin
          emit      = 1'b1;
          e_kind    = KIND_ERASE;
          e_cnt     = cnt_r - ptr_r;
          e_last    = 1'b1;
          cnt_nxt   = ptr_r;
          state_nxt = S_IDLE;
        end
      end

      S_XSCAN: begin
        if (rd_space) begin
          len_nxt   = ptr_r;
          tail_nxt  = LAST_CNT - ptr_r;
          copy_nxt  = 1'b1;
          state_nxt = S_TERASE;
        end else begin
          ptr_nxt = ptr_r - ONE;
          if (ptr_r == ONE) begin
            // no space at all: the full line is emitted
            idx_nxt   = '0;
            len_nxt   = LAST_CNT;
            copy_nxt  = 1'b0;
            state_nxt = S_LINE;
          end else begin
            ram_rsel = ptr_r - TWO;
          end
        end
      end

      S_TERASE: begin
        if (slot) begin
          emit      = 1'b1;
          e_kind    = KIND_ERASE;
          e_cnt     = tail_r;
          idx_nxt   = '0;
          state_nxt = S_LINE;
        end
      end

      S_LINE: begin
        if (idx_r == len_r) begin
          ram_rsel  = len_r;
          state_nxt = S_LEND;
        end else begin
          ram_rsel = idx_r;
          if (slot) begin
            emit     = 1'b1;
            e_kind   = KIND_LINE;
            e_byte   = ram_rdata;
            idx_nxt  = idx_r + ONE;
            ram_rsel = idx_r + ONE;
          end
        end
      end

      S_LEND: begin
        ram_rsel = len_r;
        if (slot) begin
          emit    = 1'b1;
          e_kind  = KIND_END;
          e_byte  = NEWLINE_BYTE;
          e_last  = !copy_r;
          idx_nxt = '0;
          if (copy_r) begin
            cnt_nxt   = tail_r;
            state_nxt = S_COPY;
          end else begin
            cnt_nxt   = '0;
            state_nxt = S_IDLE;
          end
        end
      end

      S_COPY: begin
        // read entry p+i, write entry i; p is at least one so they never collide
        ram_rsel = len_r + idx_r;
        if (slot) begin
          emit      = 1'b1;
          e_kind    = KIND_ECHO;
          e_byte    = ram_rdata;
          ram_we    = 1'b1;
          ram_wsel  = idx_r;
          ram_wdata = ram_rdata;
          idx_nxt   = idx_r + ONE;
          ram_rsel  = len_r + idx_r + ONE;
          if (idx_r == tail_r - ONE) begin
            e_last    = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      done_r      <= 1'b0;
      copy_r      <= 1'b0;
      wphase_r    <= 1'b0;
      out_valid_r <= 1'b0;
      eof_r       <= EOF_RST;
      erase_r     <= ERASE_RST;
      kill_r      <= KILL_RST;
      werase_r    <= WERASE_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      done_r      <= done_nxt;
      copy_r      <= copy_nxt;
      wphase_r    <= wphase_nxt;
      out_valid_r <= emit || (out_valid_r && !out_ready);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_EOF:    eof_r    <= cfg_wdata;
          REG_ERASE:  erase_r  <= cfg_wdata;
          REG_KILL:   kill_r   <= cfg_wdata;
          REG_WERASE: werase_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    c_r    <= c_nxt;
    ptr_r  <= ptr_nxt;
    idx_r  <= idx_nxt;
    len_r  <= len_nxt;
    tail_r <= tail_nxt;
    if (emit) begin
      kind_r  <= e_kind;
      byte_r  <= e_byte;
      cols_r  <= sat_cols(e_cnt);
      ended_r <= e_ended;
      last_r  <= e_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_byte          = byte_r;
  assign out_erase_columns = cols_r;
  assign out_input_ended   = ended_r;
  assign out_last_result   = last_r;

  // line never exceeds LINE_LEN between items
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cnt_r <= FULL_CNT))
    else $error("line count above LINE_LEN in idle");

  // end of input is flagged together with its marker
  a_eof_marker: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> (out_valid && out_kind == KIND_END && out_input_ended && out_last_result))
    else $error("end of input without its marker");

  // stores stay inside the line buffer
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (ram_wsel <= FULL_CNT))
    else $error("line store write out of range");

  // word erase always removes at least one column
  a_werase_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WFIN) |-> (ptr_r < cnt_r))
    else $error("word erase with nothing removed");

endmodule

// ===== tb/tty_result_checker.sv =====
`timescale 1ns / 1ps
module tty_result_checker
  import tlw_pkg::*;
#(
  parameter int LINE_LEN = LINE_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [DATA_W-1:0]    in_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [KIND_W-1:0]    out_kind,
  input  logic [DATA_W-1:0]    out_byte,
  input  logic [COLS_W-1:0]    out_erase_columns,
  input  logic                 out_input_ended,
  input  logic                 out_last_result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  output int                   fail_count,
  output int                   pending,
  output int                   line_len,
  output int                   keys_seen,
  output int                   results_seen,
  output int                   wraps_seen
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] data;
    logic [COLS_W-1:0] cols;
    logic              ended;
    logic              last;
  } tty_result_t;

  logic [DATA_W-1:0] eof_key, erase_key, kill_key, werase_key;
  logic [DATA_W-1:0] line_buf [0:LINE_LEN];
  bit                stream_ended;
  tty_result_t       step_q[$];
  tty_result_t       expected_q[$];

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: expected %0d, got %0d",
                                results_seen, name, want, got));
  endtask

  function automatic void push_result(input logic [KIND_W-1:0] kind,
                                      input logic [DATA_W-1:0] data,
                                      input int cols, input logic ended);
    tty_result_t r;
    r.kind  = kind;
    r.data  = data;
    r.cols  = (cols > COLS_MAX) ? COLS_W'(COLS_MAX) : COLS_W'(cols);
    r.ended = ended;
    r.last  = 1'b0;
    step_q.push_back(r);
  endfunction

  function automatic void push_erase(input int cols);
    if (cols > 0) push_result(KIND_ERASE, '0, cols, 1'b0);
  endfunction

  function automatic void push_line(input int len);
    int i;
    for (i = 0; i < len && i <= LINE_LEN; i++)
      push_result(KIND_LINE, line_buf[i], 0, 1'b0);
    push_result(KIND_END, NEWLINE_BYTE, 0, 1'b0);
  endfunction

  // One typed byte: update the line and queue the results it causes.
  function automatic void predict_key(input logic [DATA_W-1:0] c);
    int start, p, tail, i;
    tty_result_t r;
    step_q.delete();
    if (stream_ended) return;
    if (c == eof_key) begin
      if (line_len == 0) begin
        push_result(KIND_END, NEWLINE_BYTE, 0, 1'b1);
        stream_ended = 1'b1;
      end
    end else if (c == erase_key) begin
      if (line_len > 0) begin
        line_len--;
        push_erase(1);
      end
    end else if (c == kill_key) begin
      push_erase(line_len);
      line_len = 0;
    end else if (c == werase_key) begin
      start = line_len;
      while (line_len > 0 && line_buf[line_len-1] == SPACE_BYTE) line_len--;
      while (line_len > 0 && line_buf[line_len-1] != SPACE_BYTE) line_len--;
      push_erase(start - line_len);
    end else if (c == NEWLINE_BYTE) begin
      push_line(line_len);
      line_len = 0;
    end else if (c < SPACE_BYTE || c > TILDE_BYTE) begin
      push_result(KIND_BELL, BELL_BYTE, 0, 1'b0);
    end else begin
      push_result(KIND_ECHO, c, 0, 1'b0);
      if (line_len <= LINE_LEN) begin
        line_buf[line_len] = c;
        line_len++;
      end
      if (line_len > LINE_LEN) begin
        wraps_seen++;
        p = line_len;
        while (p > 0 && line_buf[p-1] != SPACE_BYTE) p--;
        if (p > 0) begin
          // break at last space: rub out tail, emit head, re-echo tail
          tail = line_len - p;
          push_erase(tail);
          push_line(p);
          for (i = 0; i < tail; i++) line_buf[i] = line_buf[p+i];
          line_len = tail;
          for (i = 0; i < tail; i++) push_result(KIND_ECHO, line_buf[i], 0, 1'b0);
        end else begin
          push_line(line_len);
          line_len = 0;
        end
      end
    end
    if (step_q.size() > 0) begin
      r = step_q.pop_back();
      r.last = 1'b1;
      step_q.push_back(r);
    end
    while (step_q.size() > 0) expected_q.push_back(step_q.pop_front());
  endfunction

  always @(posedge clk) begin
    tty_result_t want;
    if (!rst_n) begin
      eof_key      = EOF_RST;
      erase_key    = ERASE_RST;
      kill_key     = KILL_RST;
      werase_key   = WERASE_RST;
      line_len     = 0;
      stream_ended = 1'b0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte %0d",
                                    out_kind, out_byte));
        end else begin
          want = expected_q.pop_front();
          check_field("kind", 8'(want.kind), 8'(out_kind));
          check_field("byte", want.data, out_byte);
          check_field("erase_columns", 8'(want.cols), 8'(out_erase_columns));
          check_field("input_ended", 8'(want.ended), 8'(out_input_ended));
          check_field("last_result", 8'(want.last), 8'(out_last_result));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_EOF:    eof_key    = cfg_wdata;
          REG_ERASE:  erase_key  = cfg_wdata;
          REG_KILL:   kill_key   = cfg_wdata;
          REG_WERASE: werase_key = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        keys_seen++;
        predict_key(in_byte);
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== tb/tty_line_editor_with_wrap_test.sv =====
`timescale 1ns / 1ps
module tty_line_editor_with_wrap_test;
  import tlw_pkg::*;

  localparam int LINE_LEN       = LINE_LEN_DEF;
  localparam int RANDOM_KEYS    = 470;
  localparam int DRAIN_CYCLES   = 100;   // longer than the worst wrap walk
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all

  localparam logic [DATA_W-1:0] LOWER_A = 8'h61;
  localparam logic [DATA_W-1:0] LOWER_Z = 8'h7A;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [DATA_W-1:0]    in_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic [KIND_W-1:0]    out_kind;
  logic [DATA_W-1:0]    out_byte;
  logic [COLS_W-1:0]    out_erase_columns;
  logic                 out_input_ended;
  logic                 out_last_result;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_wdata;

  // checker status
  int fail_count, pending, line_len, keys_seen, results_seen, wraps_seen;

  // copy of the control bytes as last written, used to steer stimulus
  logic [DATA_W-1:0] eof_now, erase_now, kill_now, werase_now;

  int keys_sent;
  int burst_left;
  int idle_cycles;
  int hold_reqs;     // bumped by stimulus, served by the receiver
  int holds_served;
  int stall_left;
  int rx_mode;
  int rx_mode_left;

  // Opening sequence at reset settings:
  //   erase/kill/word-erase on an empty line (nothing to rub out),
  //   space and tilde at the printable edges, word-erase of one word,
  //   erase of a space, eof on a non-empty line (ignored), newline,
  //   control and high bytes ringing the bell, kill of a 2-char line,
  //   word-erase across trailing spaces, newline on an empty line.
  logic [DATA_W-1:0] opening_keys [25] = '{
    ERASE_RST, KILL_RST, WERASE_RST,
    SPACE_BYTE, TILDE_BYTE, LOWER_A, 8'h62, SPACE_BYTE, 8'h63,
    WERASE_RST, ERASE_RST, EOF_RST, NEWLINE_BYTE,
    8'h00, 8'h1F, 8'h80, 8'hFF,
    8'h78, 8'h79, KILL_RST,
    8'h77, SPACE_BYTE, SPACE_BYTE, WERASE_RST, NEWLINE_BYTE
  };

  tty_line_editor_with_wrap uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_byte          (out_byte),
    .out_erase_columns (out_erase_columns),
    .out_input_ended   (out_input_ended),
    .out_last_result   (out_last_result),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  tty_result_checker #(.LINE_LEN(LINE_LEN)) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_byte          (out_byte),
    .out_erase_columns (out_erase_columns),
    .out_input_ended   (out_input_ended),
    .out_last_result   (out_last_result),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .fail_count        (fail_count),
    .pending           (pending),
    .line_len          (line_len),
    .keys_seen         (keys_seen),
    .results_seen      (results_seen),
    .wraps_seen        (wraps_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d results still due",
               WATCHDOG_LIMIT, pending);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random ready pattern in modes of random length
  // (always ready / coin flip / mostly stalled), plus a long counted
  // hold-off on request so the block backs up into its input.
  initial begin
    out_ready    = 1'b0;
    holds_served = 0;
    stall_left   = 0;
    rx_mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_served) begin
        holds_served = hold_reqs;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      = $urandom_range(0, 2);
          rx_mode_left = $urandom_range(5, 60);
        end
        rx_mode_left--;
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Offer one byte and hold it until taken. Bytes go out in bursts of
  // random length; a burst starts after a random gap, sometimes none.
  // Called and returns at a falling edge; in_valid stays high on return
  // so back-to-back items never drop valid in between.
  task automatic send_key(input logic [DATA_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    keys_sent++;
  endtask

  // Same, but an eof on an empty line would end the stream for good,
  // so that one case is kept for the very end of the run.
  task automatic type_key(input logic [DATA_W-1:0] b);
    if (b == eof_now && line_len == 0) b = LOWER_Z;
    send_key(b);
  endtask

  // Stop offering until every predicted result is out, then give the
  // block time to finish an item that produced nothing.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_EOF:    eof_now    = val;
      REG_ERASE:  erase_now  = val;
      REG_KILL:   kill_now   = val;
      REG_WERASE: werase_now = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_keys(input logic [DATA_W-1:0] eof_b, erase_b, kill_b, werase_b);
    wait_drained();
    write_reg(REG_EOF, eof_b);
    write_reg(REG_ERASE, erase_b);
    write_reg(REG_KILL, kill_b);
    write_reg(REG_WERASE, werase_b);
    cfg_we <= 1'b0;
  endtask

  // mostly lowercase, now and then any printable but space
  function automatic logic [DATA_W-1:0] word_char();
    if ($urandom_range(0, 9) == 0) return DATA_W'($urandom_range(33, 126));
    return LOWER_A + DATA_W'($urandom_range(0, 25));
  endfunction

  // words and spaces, sometimes closed by a newline; open lines wrap
  task automatic type_words();
    int words, len;
    words = $urandom_range(1, 12);
    repeat (words) begin
      len = $urandom_range(1, 10);
      repeat (len) type_key(word_char());
      repeat ($urandom_range(1, 2)) type_key(SPACE_BYTE);
    end
    if ($urandom_range(0, 9) < 3) type_key(NEWLINE_BYTE);
  endtask

  // bring the line to the margin, then cross it with a space (empty
  // tail, nothing re-echoed) or with a letter (normal break)
  task automatic fill_to_margin();
    while (line_len < LINE_LEN)
      type_key(($urandom_range(0, 5) == 0) ? SPACE_BYTE : word_char());
    type_key($urandom_range(0, 1) ? SPACE_BYTE : word_char());
  endtask

  // clear the line, then one unbroken word past the margin
  task automatic type_long_word();
    type_key(kill_now);
    repeat ($urandom_range(LINE_LEN + 1, LINE_LEN + 20)) type_key(word_char());
  endtask

  task automatic type_edits();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 6))
        0: type_key(erase_now);
        1: type_key(kill_now);
        2: type_key(werase_now);
        3: type_key(NEWLINE_BYTE);
        4: type_key(eof_now);
        5: type_key(DATA_W'($urandom_range(0, 31)));
        default: type_key(DATA_W'($urandom_range(128, 255)));
      endcase
    end
  endtask

  task automatic type_noise();
    repeat ($urandom_range(1, 6)) type_key(DATA_W'($urandom_range(0, 255)));
  endtask

  task automatic random_phase(input int count);
    int target, pick;
    target = keys_sent + count;
    while (keys_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)      type_words();
      else if (pick < 65) fill_to_margin();
      else if (pick < 73) type_long_word();
      else if (pick < 88) type_edits();
      else                type_noise();
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_byte    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    eof_now    = EOF_RST;
    erase_now  = ERASE_RST;
    kill_now   = KILL_RST;
    werase_now = WERASE_RST;
    keys_sent  = 0;
    burst_left = 0;
    hold_reqs  = 0;
    idle_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (opening_keys[i]) send_key(opening_keys[i]);

    // reset settings; long result hold-off partway through while the
    // sender keeps offering
    random_phase(RANDOM_KEYS / 8);
    hold_reqs++;
    random_phase(RANDOM_KEYS / 8);

    // extremes: eof at 255, kill at 0, DEL now word-erase; sender pauses
    // mid-phase until everything is out
    set_keys(8'hFF, 8'h08, 8'h00, ERASE_RST);
    random_phase(RANDOM_KEYS / 8);
    wait_drained();
    random_phase(RANDOM_KEYS / 8);

    // eof at 0, erase at 255, a printable kill, newline shadowed by
    // word-erase
    set_keys(8'h00, 8'hFF, 8'h40, NEWLINE_BYTE);
    random_phase(RANDOM_KEYS / 4);

    // back to reset values, end the stream on an empty line, then a few
    // bytes that must be ignored
    set_keys(EOF_RST, ERASE_RST, KILL_RST, WERASE_RST);
    random_phase(RANDOM_KEYS / 4);
    type_key(NEWLINE_BYTE);
    send_key(eof_now);
    send_key(LOWER_A);
    send_key(NEWLINE_BYTE);
    send_key(8'hFF);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d bytes (%0d taken) across four control-byte settings, ending on eof.",
             keys_sent, keys_seen);
    $display("Checked %0d results; %0d line wraps predicted.", results_seen, wraps_seen);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tlw_pkg.sv
sv/tlw_ram.sv
sv/tty_line_editor_with_wrap.sv
tb/tty_result_checker.sv
tb/tty_line_editor_with_wrap_test.sv
